### rtl/fphp_pkg.sv
// package for float_pair_to_half_pack: types and constants
package fphp_pkg;
	localparam logic [30:0] MagInf    = 31'h7F800000;
	localparam logic [30:0] MagOvf    = 31'h477FF000;
	localparam logic [30:0] MagNormal = 31'h38800000;
	localparam logic [30:0] ExpBias   = 31'h38000000;
	localparam logic [14:0] HalfNan   = 15'h7E00;
	localparam logic [14:0] HalfInf   = 15'h7C00;

	typedef enum logic [2:0] {
		CLS_NAN,
		CLS_INF,
		CLS_ZERO,
		CLS_SUB,
		CLS_NORM
	} cls_t;

	// classified operand after stage one
	typedef struct packed {
		logic        sign;
		cls_t        cls;
		logic [30:0] mag;
		logic [4:0]  sh;
	} cls_word_t;
endpackage

### rtl/fphp_classify.sv
// stage one logic: sort a single-precision pattern into its conversion case
module fphp_classify import fphp_pkg::*; (
	input  logic [31:0] bits,
	output cls_word_t   word
);
	logic [30:0] mag;
	logic [7:0]  expo;
	logic [7:0]  sh_full;

	assign mag     = bits[30:0];
	assign expo    = mag[30:23];
	assign sh_full = 8'd126 - expo;

	always_comb begin
		word.sign = bits[31];
		word.mag  = mag;
		word.sh   = sh_full[4:0];
		if (mag > MagInf) begin
			word.cls = CLS_NAN;
		end else if (mag >= MagOvf) begin
			word.cls = CLS_INF;
		end else if (mag >= MagNormal) begin
			word.cls = CLS_NORM;
		end else if (expo == 8'd0 || sh_full > 8'd25) begin
			word.cls = CLS_ZERO;
		end else begin
			word.cls = CLS_SUB;
		end
	end
endmodule

### rtl/fphp_round.sv
// stage two logic: rounding add for the normal and subnormal cases
module fphp_round import fphp_pkg::*; (
	input  cls_word_t   word,
	output logic [31:0] sum
);
	logic [24:0] sig;
	logic [25:0] half_ulp;

	assign sig      = {2'b01, word.mag[22:0]};
	assign half_ulp = 26'd1 << (word.sh - 5'd1);

	always_comb begin
		if (word.cls == CLS_SUB) begin
			sum = {6'd0, {1'b0, sig} + half_ulp};
		end else begin
			sum = {1'b0, word.mag} + 32'hFFF + {31'd0, word.mag[13]};
		end
	end
endmodule

### rtl/fphp_pack.sv
// stage three logic: final shift and special-value select
module fphp_pack import fphp_pkg::*; (
	input  cls_word_t   word,
	input  logic [31:0] sum,
	output logic [15:0] half
);
	logic [31:0] norm;
	logic [25:0] sub;

	assign norm = (sum - {1'b0, ExpBias}) >> 13;
	assign sub  = sum[25:0] >> word.sh;

	always_comb begin
		unique case (word.cls)
			CLS_NAN:  half = {word.sign, HalfNan};
			CLS_INF:  half = {word.sign, HalfInf};
			CLS_ZERO: half = {word.sign, 15'd0};
			CLS_SUB:  half = {word.sign, sub[14:0]};
			CLS_NORM: half = {word.sign, norm[14:0]};
			default:  half = {word.sign, 15'd0};
		endcase
	end
endmodule

### rtl/float_pair_to_half_pack.sv
// top level: two-lane float32 to float16 converter and packer
//
// usage
//  - input channel: valid/ready with first_float and second_float, one
//    transaction carries one pair of single-precision bit patterns
//  - output channel: valid/ready with packed_halves, half of first_float
//    in bits 15..0 and half of second_float in bits 31..16
//  - path: an accepted pair is registered in s1, then s2, then s3, and
//    out_valid comes straight from the s3 valid bit
//  - one pair per cycle unless the receiver stalls; each lane has its own
//    classify, round and pack logic; the two values share only the handshake
//  - stages: s1 classify, s2 rounding add, s3 shift/select (output reg)
//  - when the receiver stalls, the pipeline compresses: a stage holds
//    while the stage after it is full and stalled, empty stages fill up,
//    and ready drops only when all three stages hold a transaction
//  - reset clears the valid bits; data registers are not reset
module float_pair_to_half_pack import fphp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] first_float,
	input  logic [31:0] second_float,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packed_halves
);
	cls_word_t   cls_a, cls_b, w_a_s1, w_b_s1, w_a_s2, w_b_s2;
	logic [31:0] sum_a, sum_b, sum_a_s2, sum_b_s2;
	logic [15:0] half_a, half_b;
	logic [31:0] out_s3;
	logic        v_s1, v_s2, v_s3;
	logic        en_s1, en_s2, en_s3;

	// per-stage advance: a stage loads when it is empty or its content moves on
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	fphp_classify u_cls_a (.bits(first_float),  .word(cls_a));
	fphp_classify u_cls_b (.bits(second_float), .word(cls_b));
	fphp_round    u_rnd_a (.word(w_a_s1), .sum(sum_a));
	fphp_round    u_rnd_b (.word(w_b_s1), .sum(sum_b));
	fphp_pack     u_pck_a (.word(w_a_s2), .sum(sum_a_s2), .half(half_a));
	fphp_pack     u_pck_b (.word(w_b_s2), .sum(sum_b_s2), .half(half_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en_s1) begin
			w_a_s1 <= cls_a;
			w_b_s1 <= cls_b;
		end
		if (en_s2) begin
			w_a_s2   <= w_a_s1;
			w_b_s2   <= w_b_s1;
			sum_a_s2 <= sum_a;
			sum_b_s2 <= sum_b;
		end
		if (en_s3) begin
			out_s3 <= {half_b, half_a};
		end
	end

	assign out_valid     = v_s3;
	assign packed_halves = out_s3;
endmodule
